### design/priority_fifo_replacement_macros.svh
//------------------------------------------------------------------------------
// Priority FIFO replacement assertion macros
// Shared assertion forms used by the top level.
//------------------------------------------------------------------------------
`ifndef PRIORITY_FIFO_REPLACEMENT_MACROS_SVH
`define PRIORITY_FIFO_REPLACEMENT_MACROS_SVH

// Checks that an implication holds at every clock edge outside reset.
`define PFR_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Checks that an implication holds in the next cycle outside reset.
`define PFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### design/pfr_pkg.sv
//------------------------------------------------------------------------------
// Priority FIFO replacement package
// Shared types, codes and constants.
//------------------------------------------------------------------------------
package pfr_pkg;

  localparam int SlotCountDefault = 1024;
  localparam int MaxEvictDefault  = 64;
  localparam int SlotW            = 10;
  localparam int LimitW           = 11;
  localparam logic [LimitW-1:0] LimitReset = 11'd1024;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_REFRESH = 2'd1,
    OP_ERASE   = 2'd2,
    OP_STALE   = 2'd3
  } op_t;

  localparam logic [1:0] Q_FRESH = 2'd0;
  localparam logic [1:0] Q_STALE = 2'd1;
  localparam logic [1:0] Q_UNSOL = 2'd2;

  typedef struct packed {
    logic [1:0]       op;
    logic [SlotW-1:0] slot;
    logic [1:0]       entry_class;
  } item_in_t;

  typedef struct packed {
    logic [SlotW-1:0] evicted_slot;
    logic [1:0]       evicted_queue;
    logic             last;
  } item_out_t;

  // Classified command passed from front to back.
  typedef struct packed {
    logic [1:0]       op;
    logic [SlotW-1:0] slot;
    logic [1:0]       q;
  } cmd_t;

endpackage

### design/priority_fifo_replacement.sv
//------------------------------------------------------------------------------
// Priority FIFO replacement
// Slot replacement policy with three FIFO queues and priority eviction.
//------------------------------------------------------------------------------
// After reset the back end clears the class store (SLOT_COUNT entries, 1024 by
// default); items are queued meanwhile and busy rises once the two-entry
// queue is full. The back end then steps through READ and DET for every item,
// adds ATT and ATT2 for a refresh or a mark_stale that moves a slot and for an
// insert, and CHECK for an insert, plus EVREAD, EVDET and CHECK per eviction.
// The two-entry queue lets start be taken while the back end works.
// Evictions appear one item per done strobe, and the receiver cannot stall
// them.
`include "priority_fifo_replacement_macros.svh"
module priority_fifo_replacement #(
  parameter int SLOT_COUNT           = pfr_pkg::SlotCountDefault,
  parameter int MAX_EVICT_PER_INSERT = pfr_pkg::MaxEvictDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  pfr_pkg::item_in_t   item_in,
  output logic                done,
  output pfr_pkg::item_out_t  result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [pfr_pkg::LimitW-1:0] capacity_limit;
  logic          cmd_valid;
  logic          cmd_take;
  pfr_pkg::cmd_t cmd;
  logic          idle;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {21'd0, capacity_limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= pfr_pkg::LimitReset;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      capacity_limit <= pwdata[pfr_pkg::LimitW-1:0];
    end
  end

  pfr_front #(.SLOT_COUNT(SLOT_COUNT)) u_front (
    .clk, .rst, .start, .item_in, .busy, .cmd_valid, .cmd, .cmd_take
  );

  pfr_back #(
    .SLOT_COUNT(SLOT_COUNT), .MAX_EVICT_PER_INSERT(MAX_EVICT_PER_INSERT)
  ) u_back (
    .clk, .rst, .cmd_valid, .cmd, .cmd_take, .limit(capacity_limit),
    .done, .result, .idle
  );

  `PFR_ASSERT_IMPL(a_take_needs_valid, clk, rst, cmd_take, cmd_valid)
  `PFR_ASSERT_IMPL(a_done_queue_ok, clk, rst, done, result.evicted_queue != 2'd3)
  `PFR_ASSERT_NEXT(a_done_single, clk, rst, done, !done)
  `PFR_ASSERT_IMPL(a_busy_not_idle, clk, rst, busy, !idle)

endmodule

### design/pfr_front.sv
//------------------------------------------------------------------------------
// Priority FIFO replacement front end
// Accepts items, classifies them and queues commands for the back end.
//------------------------------------------------------------------------------
module pfr_front #(
  parameter int SLOT_COUNT = pfr_pkg::SlotCountDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  pfr_pkg::item_in_t  item_in,
  output logic               busy,
  output logic               cmd_valid,
  output pfr_pkg::cmd_t      cmd,
  input  logic               cmd_take
);

  pfr_pkg::cmd_t fifo [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          accept;
  logic          in_range;
  logic          push;
  pfr_pkg::cmd_t incoming;

  assign busy      = (count == 2'd2);
  assign accept    = start && !busy;
  assign in_range  = ({22'd0, item_in.slot} < 32'(SLOT_COUNT));
  assign push      = accept && in_range;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = fifo[rd_ptr];

  always_comb begin
    incoming.op   = item_in.op;
    incoming.slot = item_in.slot;
    incoming.q    = (item_in.entry_class == 2'd3) ? pfr_pkg::Q_UNSOL : item_in.entry_class;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_take) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, cmd_take};
    end
  end

endmodule

### design/pfr_back.sv
//------------------------------------------------------------------------------
// Priority FIFO replacement back end
// Executes commands on the linked queues and emits evictions.
//------------------------------------------------------------------------------
module pfr_back #(
  parameter int SLOT_COUNT           = pfr_pkg::SlotCountDefault,
  parameter int MAX_EVICT_PER_INSERT = pfr_pkg::MaxEvictDefault
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_valid,
  input  pfr_pkg::cmd_t               cmd,
  output logic                        cmd_take,
  input  logic [pfr_pkg::LimitW-1:0]  limit,
  output logic                        done,
  output pfr_pkg::item_out_t          result,
  output logic                        idle
);

  localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int OW = pfr_pkg::LimitW + 1;
  localparam int EW = $clog2(MAX_EVICT_PER_INSERT + 1);
  localparam int SW = pfr_pkg::SlotW;

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_READ   = 9'b000000100,
    S_DET    = 9'b000001000,
    S_ATT    = 9'b000010000,
    S_ATT2   = 9'b000100000,
    S_CHECK  = 9'b001000000,
    S_EVREAD = 9'b010000000,
    S_EVDET  = 9'b100000000
  } state_t;

  state_t state;

  // Class store holds zero for an untracked slot, else the queue code plus one.
  logic [1:0]    cls_mem  [SLOT_COUNT];
  logic [AW-1:0] next_mem [SLOT_COUNT];
  logic [AW-1:0] prev_mem [SLOT_COUNT];

  logic [AW-1:0] head [3];
  logic [AW-1:0] tail [3];
  logic [2:0]    nonempty;
  logic [OW-1:0] occupancy;
  logic [EW-1:0] evict_count;
  logic [AW-1:0] clr_addr;

  pfr_pkg::cmd_t cur;
  logic [AW-1:0] s;
  logic [1:0]    s_code;
  logic [1:0]    s_q;
  logic          s_tracked;
  logic [AW-1:0] s_prev;
  logic [AW-1:0] s_next;
  logic          is_head;
  logic          is_tail;
  logic          det_now;
  logic          att_next;
  logic [1:0]    att_q_next;
  logic [1:0]    att_q;
  logic [1:0]    ev_q;
  logic [1:0]    pick_q;
  logic          excess;
  logic          any_ne;
  logic [OW-1:0] occ_after;

  assign idle      = (state == S_IDLE) && !cmd_valid;
  assign cmd_take  = (state == S_IDLE) && cmd_valid;
  assign excess    = ({1'b0, limit} < occupancy)
                     && (evict_count < EW'(MAX_EVICT_PER_INSERT));
  assign any_ne    = |nonempty;
  assign occ_after = occupancy - OW'(1);
  assign s_tracked = (s_code != 2'd0);
  assign s_q       = s_code - 2'd1;
  assign is_head   = (head[s_q] == s);
  assign is_tail   = (tail[s_q] == s);

  always_comb begin
    if (nonempty[pfr_pkg::Q_UNSOL]) begin
      pick_q = pfr_pkg::Q_UNSOL;
    end else if (nonempty[pfr_pkg::Q_STALE]) begin
      pick_q = pfr_pkg::Q_STALE;
    end else begin
      pick_q = pfr_pkg::Q_FRESH;
    end
  end

  always_comb begin
    det_now    = 1'b0;
    att_next   = 1'b0;
    att_q_next = cur.q;
    if (state == S_EVDET) begin
      det_now = 1'b1;
    end else if (state == S_DET) begin
      case (cur.op)
        pfr_pkg::OP_INSERT: begin
          det_now  = s_tracked;
          att_next = 1'b1;
        end
        pfr_pkg::OP_REFRESH: begin
          det_now  = s_tracked;
          att_next = s_tracked;
        end
        pfr_pkg::OP_ERASE: begin
          det_now = s_tracked;
        end
        default: begin
          det_now    = (s_code == pfr_pkg::Q_FRESH + 2'd1);
          att_next   = det_now;
          att_q_next = pfr_pkg::Q_STALE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      cls_mem[clr_addr] <= 2'd0;
    end
    if (state == S_READ || state == S_EVREAD) begin
      s_code <= cls_mem[s];
      s_prev <= prev_mem[s];
      s_next <= next_mem[s];
    end
    if (det_now) begin
      cls_mem[s] <= 2'd0;
      if (!is_head) begin
        next_mem[s_prev] <= s_next;
      end
      if (!is_tail) begin
        prev_mem[s_next] <= s_prev;
      end
    end
    if (state == S_ATT) begin
      if (nonempty[att_q]) begin
        next_mem[tail[att_q]] <= s;
        prev_mem[s]           <= tail[att_q];
      end else begin
        prev_mem[s] <= s;
      end
      cls_mem[s] <= att_q + 2'd1;
    end
    if (state == S_ATT2) begin
      next_mem[s] <= s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      nonempty    <= '0;
      occupancy   <= '0;
      evict_count <= '0;
      done        <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(SLOT_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            cur         <= cmd;
            s           <= cmd.slot[AW-1:0];
            evict_count <= '0;
            state       <= S_READ;
          end
        end
        S_READ: begin
          state <= S_DET;
        end
        S_DET: begin
          att_q <= att_q_next;
          if (cur.op == pfr_pkg::OP_INSERT && !s_tracked) begin
            occupancy <= occupancy + OW'(1);
          end
          if (cur.op == pfr_pkg::OP_ERASE && s_tracked) begin
            occupancy <= occupancy - OW'(1);
          end
          state <= att_next ? S_ATT : S_IDLE;
        end
        S_ATT: begin
          if (!nonempty[att_q]) begin
            head[att_q] <= s;
          end
          nonempty[att_q] <= 1'b1;
          tail[att_q]     <= s;
          state           <= S_ATT2;
        end
        S_ATT2: begin
          state <= (cur.op == pfr_pkg::OP_INSERT) ? S_CHECK : S_IDLE;
        end
        S_CHECK: begin
          if (excess && any_ne) begin
            s     <= head[pick_q];
            ev_q  <= pick_q;
            state <= S_EVREAD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_EVREAD: begin
          state <= S_EVDET;
        end
        S_EVDET: begin
          occupancy            <= occ_after;
          evict_count          <= evict_count + EW'(1);
          done                 <= 1'b1;
          result.evicted_slot  <= SW'(s);
          result.evicted_queue <= ev_q;
          result.last          <= !(({1'b0, limit} < occ_after)
                                    && (evict_count + EW'(1) < EW'(MAX_EVICT_PER_INSERT)));
          state                <= S_CHECK;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (det_now) begin
        if (is_head && is_tail) begin
          nonempty[s_q] <= 1'b0;
        end else begin
          if (is_head) begin
            head[s_q] <= s_next;
          end
          if (is_tail) begin
            tail[s_q] <= s_prev;
          end
        end
      end
    end
  end

endmodule
